### sv/rsp_pkg.sv
package rsp_pkg;

  localparam int unsigned BufferCount     = 8;
  localparam int unsigned SectorSize      = 512;
  localparam int unsigned FrameHeaderSize = 12;
  localparam int unsigned BlockHeaderSize = 8;
  localparam int unsigned RecBase         = FrameHeaderSize + BlockHeaderSize;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_POP     = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_PUBLISHED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_CLOSED    = 3'd3,
    ST_DECIMATED = 3'd4,
    ST_WORD      = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_DISCARDED = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_STREAM_TAG = 3'd1,
    REG_REC_BYTES  = 3'd2,
    REG_REC_PER    = 3'd3,
    REG_MIN_GAP    = 3'd4,
    REG_BLOCK_TYPE = 3'd5,
    REG_SENTINEL   = 3'd6,
    REG_NONE       = 3'd7
  } reg_e;

  // one queued command, front to back
  typedef struct packed {
    kind_e          kind;
    logic [31:0]    time_stamp;
    logic [255:0]   rec;
  } cmd_t;

endpackage

### sv/rsp_ram.sv
module rsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/rsp_front.sv
module rsp_front
  import rsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] time_stamp_i,
  input  logic [63:0] rec_word0_i,
  input  logic [63:0] rec_word1_i,
  input  logic [63:0] rec_word2_i,
  input  logic [63:0] rec_word3_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output cmd_t        q_cmd_o
);

  // small fifo; unused kinds are dropped on entry
  cmd_t             buf_q [QueueDepth];
  logic [0:0]       wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;
  cmd_t             cmd_in;

  assign cmd_in.kind       = kind_e'(kind_i);
  assign cmd_in.time_stamp = time_stamp_i;
  assign cmd_in.rec        = {rec_word3_i, rec_word2_i, rec_word1_i, rec_word0_i};

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = buf_q[rp_q];
  assign pop        = q_valid_o && q_ready_i;
  assign push       = in_valid_i && in_ready_o && (kind_e'(kind_i) != KIND_UNUSED);

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/rsp_back.sv
module rsp_back
  import rsp_pkg::*;
#(
  parameter int unsigned BufCount = BufferCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  cmd_t        q_cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] sector_word_o,
  output logic        last_word_o,
  output logic [8:0]  records_in_sector_o,
  output logic [7:0]  queued_sectors_o,
  output logic [31:0] dropped_total_o
);

  localparam int unsigned SecSize = SectorSize;
  localparam int unsigned SlotW  = $clog2(BufCount);
  localparam int unsigned OffW   = $clog2(SecSize);
  localparam int unsigned AddrW  = $clog2(BufCount * SecSize);
  localparam int unsigned Words0 = SecSize / 8;
  localparam int unsigned Words  = (Words0 > 64) ? 64 : Words0;
  localparam int unsigned WordW  = $clog2(Words);
  localparam int unsigned StoreD = BufCount * SecSize;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HDR, S_REC, S_META, S_RESULT, S_POPRD, S_POPOUT, S_WAIT
  } state_e;

  state_e            state_q;
  logic              enable_q;
  logic [7:0]        tag_q, btype_q, sent_q;
  logic [5:0]        rbytes_q;
  logic [8:0]        rps_q;
  logic [31:0]       gap_q;

  logic [SlotW-1:0]  fill_q, drain_q, rd_slot_q;
  logic [8:0]        count_q;
  logic [31:0]       last_t_q, drop_q;
  cmd_t              cmd_q;
  logic [5:0]        rb_q;
  logic [OffW+9:0]   base_q;
  logic [5:0]        i_q;
  logic [AddrW:0]    clr_q;
  logic [WordW:0]    w_q;
  logic [3:0]        b_q;
  logic [63:0]       acc_q;
  logic [2:0]        pend_st_q;

  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [63:0]       word_q;
  logic              last_q;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [7:0]        wdata, rdata;
  logic [SlotW:0]    qd;
  logic [31:0]       tdiff;
  logic [8:0]        cnt_inc, rps_eff;
  logic [SlotW-1:0]  fill_nxt;
  logic [OffW+9:0]   roff;
  logic              out_free;
  logic              out_load;

  rsp_ram #(.Width(8), .Depth(StoreD)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_ready_o = (state_q != S_CLEAR);
  assign qd = (fill_q >= drain_q) ?
              (SlotW+1)'({1'b0, fill_q} - {1'b0, drain_q}) :
              (SlotW+1)'({1'b0, fill_q} + (SlotW+1)'(BufCount) - {1'b0, drain_q});
  assign tdiff = cmd_q.time_stamp - last_t_q;
  assign cnt_inc = count_q + 9'd1;
  assign rps_eff = (rps_q == 9'd0) ? 9'd1 : rps_q;
  assign fill_nxt = (fill_q == SlotW'(BufCount - 1)) ? '0 : fill_q + 1'b1;
  assign roff = base_q + (OffW+10)'(i_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((state_q == S_WAIT) || (state_q == S_POPOUT)) && out_free;
  assign q_ready_o = (state_q == S_IDLE) && out_free;

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign sector_word_o       = word_q;
  assign last_word_o         = last_q;
  assign records_in_sector_o = count_q;
  assign queued_sectors_o    = 8'(qd);
  assign dropped_total_o     = drop_q;

  // header steps: 0 type,1 sentinel,2..3 size,4 tag,5..8 first time
  // meta steps: 0..1 count,2..5 last time
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = AddrW'({rd_slot_q, w_q[WordW-1:0], b_q[2:0]});
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q[AddrW-1:0];
      end
      S_HDR: begin
        we = 1'b1;
        case (b_q)
          4'd0: begin waddr = AddrW'({fill_q, OffW'(0)});  wdata = btype_q; end
          4'd1: begin waddr = AddrW'({fill_q, OffW'(1)});  wdata = sent_q; end
          4'd2: begin
            waddr = AddrW'({fill_q, OffW'(2)});
            wdata = 8'(SecSize - FrameHeaderSize);
          end
          4'd3: begin
            waddr = AddrW'({fill_q, OffW'(3)});
            wdata = 8'((SecSize - FrameHeaderSize) >> 8);
          end
          4'd4: begin waddr = AddrW'({fill_q, OffW'(4)});  wdata = tag_q; end
          default: begin
            waddr = AddrW'({fill_q, OffW'(12)} + (b_q - 4'd5));
            wdata = 8'(cmd_q.time_stamp >> (8 * (b_q - 4'd5)));
          end
        endcase
      end
      S_REC: begin
        we    = (i_q < rb_q) && (roff < (OffW+10)'(SecSize));
        waddr = AddrW'({fill_q, roff[OffW-1:0]});
        wdata = cmd_q.rec[8*i_q[4:0] +: 8];
      end
      S_META: begin
        we = 1'b1;
        if (b_q < 4'd2) begin
          waddr = AddrW'({fill_q, OffW'(6)} + b_q);
          wdata = 8'({7'd0, cnt_inc} >> (8 * b_q));
        end else begin
          waddr = AddrW'({fill_q, OffW'(16)} + (b_q - 4'd2));
          wdata = 8'(cmd_q.time_stamp >> (8 * (b_q - 4'd2)));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      enable_q    <= 1'b0;
      tag_q       <= '0;
      rbytes_q    <= 6'd12;
      rps_q       <= 9'd41;
      gap_q       <= '0;
      btype_q     <= '0;
      sent_q      <= '0;
      fill_q      <= '0;
      drain_q     <= '0;
      rd_slot_q   <= '0;
      count_q     <= '0;
      last_t_q    <= '0;
      drop_q      <= '0;
      cmd_q       <= '0;
      rb_q        <= '0;
      base_q      <= '0;
      clr_q       <= '0;
      i_q         <= '0;
      w_q         <= '0;
      b_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_STORED;
      word_q      <= '0;
      last_q      <= 1'b0;
      pend_st_q   <= ST_STORED;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_ENABLE:     enable_q <= cfg_data_i[0];
          REG_STREAM_TAG: tag_q    <= cfg_data_i[7:0];
          REG_REC_BYTES:  rbytes_q <= cfg_data_i[5:0];
          REG_REC_PER:    rps_q    <= cfg_data_i[8:0];
          REG_MIN_GAP:    gap_q    <= cfg_data_i;
          REG_BLOCK_TYPE: btype_q  <= cfg_data_i[7:0];
          REG_SENTINEL:   sent_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AddrW+1)'(StoreD - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid_i && q_ready_o) begin
            cmd_q <= q_cmd_i;
            case (q_cmd_i.kind)
              KIND_RECORD: state_q <= S_RESULT;
              KIND_POP:    state_q <= S_RESULT;
              default:     state_q <= S_RESULT;
            endcase
            pend_st_q <= ST_STORED;
            b_q <= '0;
            i_q <= '0;
            w_q <= '0;
          end
        end
        S_RESULT: begin
          // classify the command at the back end
          case (cmd_q.kind)
            KIND_RECORD: begin
              if (!enable_q) begin
                pend_st_q <= ST_CLOSED;
                state_q   <= S_WAIT;
              end else if (gap_q != 32'd0 && tdiff < gap_q) begin
                pend_st_q <= ST_DECIMATED;
                state_q   <= S_WAIT;
              end else begin
                rb_q   <= (rbytes_q > 6'd32) ? 6'd32 : rbytes_q;
                base_q <= (OffW+10)'(RecBase) + (OffW+10)'(count_q) *
                          (OffW+10)'((rbytes_q > 6'd32) ? 6'd32 : rbytes_q);
                state_q <= (count_q == 9'd0) ? S_HDR : S_REC;
              end
            end
            KIND_POP: begin
              if (drain_q == fill_q) begin
                pend_st_q <= ST_EMPTY;
                state_q   <= S_WAIT;
              end else begin
                // the queue shrinks before the first word goes out
                rd_slot_q <= drain_q;
                drain_q   <= (drain_q == SlotW'(BufCount - 1)) ? '0 : drain_q + 1'b1;
                state_q   <= S_POPRD;
              end
            end
            default: begin
              drain_q   <= fill_q;
              pend_st_q <= ST_DISCARDED;
              state_q   <= S_WAIT;
            end
          endcase
        end
        S_HDR: begin
          b_q <= b_q + 4'd1;
          if (b_q == 4'd8) state_q <= S_REC;
        end
        S_REC: begin
          i_q <= i_q + 6'd1;
          if (i_q >= rb_q || i_q == 6'd31) begin
            b_q     <= '0;
            state_q <= S_META;
          end
        end
        S_META: begin
          b_q <= b_q + 4'd1;
          if (b_q == 4'd5) begin
            last_t_q <= cmd_q.time_stamp;
            if (cnt_inc >= rps_eff) begin
              count_q <= '0;
              if (fill_nxt == drain_q) begin
                drop_q    <= drop_q + 32'd1;
                pend_st_q <= ST_DROPPED;
              end else begin
                fill_q    <= fill_nxt;
                pend_st_q <= ST_PUBLISHED;
              end
            end else begin
              count_q   <= cnt_inc;
              pend_st_q <= ST_STORED;
            end
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            status_q    <= pend_st_q;
            word_q      <= '0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_POPRD: begin
          // b_q counts reads issued, data arrives the cycle after
          if (b_q != 4'd0) acc_q <= {rdata, acc_q[63:8]};
          if (b_q == 4'd8) begin
            state_q <= S_POPOUT;
          end else begin
            b_q <= b_q + 4'd1;
          end
        end
        S_POPOUT: begin
          if (out_free) begin
            status_q    <= ST_WORD;
            word_q      <= acc_q;
            b_q         <= '0;
            if (w_q == (WordW+1)'(Words - 1)) begin
              last_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              last_q  <= 1'b0;
              w_q     <= w_q + 1'b1;
              state_q <= S_POPRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/record_sector_packer_ring.sv
// channel   direction  handshake                 payload
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in        in         in_valid_i/in_ready_o     kind_i, time_stamp_i, rec_word0..3_i
// out       out        out_valid_o/out_ready_i   status_o ... dropped_total_o
// a record goes through the result, record byte and meta steps, plus the header steps for the first of a sector
// closed, decimated, empty pop and discard items go from the result step straight to the wait step
// a pop reads each sector word one byte at a time, the sector memory has one byte read port
// after reset the whole store is cleared, one byte a cycle
// a stalled result holds the engine, a two-entry command queue parts it from the input
module record_sector_packer_ring
  import rsp_pkg::*;
#(
  parameter int unsigned BufCount = BufferCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] time_stamp_i,
  input  logic [63:0] rec_word0_i,
  input  logic [63:0] rec_word1_i,
  input  logic [63:0] rec_word2_i,
  input  logic [63:0] rec_word3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] sector_word_o,
  output logic        last_word_o,
  output logic [8:0]  records_in_sector_o,
  output logic [7:0]  queued_sectors_o,
  output logic [31:0] dropped_total_o
);

  logic q_valid, q_ready;
  cmd_t q_cmd;

  rsp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .time_stamp_i,
    .rec_word0_i, .rec_word1_i, .rec_word2_i, .rec_word3_i,
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_cmd_o   (q_cmd)
  );

  rsp_back #(.BufCount(BufCount)) u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_cmd_i   (q_cmd),
    .out_valid_o, .out_ready_i, .status_o, .sector_word_o, .last_word_o,
    .records_in_sector_o, .queued_sectors_o, .dropped_total_o
  );

endmodule

### sv/rsp_checker.sv
module rsp_checker
  import rsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [63:0] sector_word_o,
  input logic        last_word_o,
  input logic [31:0] dropped_total_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sector_word_o))
    else $error("output changed while stalled");

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_WORD |-> sector_word_o == 64'd0 && last_word_o)
    else $error("single result not last or nonzero");

  a_drop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && dropped_total_o != $past(dropped_total_o) |->
      dropped_total_o == $past(dropped_total_o) + 32'd1)
    else $error("drop counter jumped");

  a_drop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_o == ST_DROPPED |-> dropped_total_o != 32'd0
      || $past(dropped_total_o) == 32'hFFFFFFFF)
    else $error("drop reported without count");

endmodule

bind record_sector_packer_ring rsp_checker u_rsp_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o, .sector_word_o,
  .last_word_o, .dropped_total_o
);
